// ===== design/dq_pkg.sv =====
package dq_pkg;

  // default sizing
  localparam int DEPTH_DEF     = 16;
  localparam int WORD_BITS_DEF = 32;

  // request codes
  localparam logic [2:0] REQ_PUSH_FRONT = 3'd0;
  localparam logic [2:0] REQ_PUSH_BACK  = 3'd1;
  localparam logic [2:0] REQ_POP_FRONT  = 3'd2;
  localparam logic [2:0] REQ_POP_BACK   = 3'd3;
  localparam logic [2:0] REQ_QUERY      = 3'd4;

  // result status codes
  typedef enum logic [1:0] {
    STAT_OK        = 2'd0,
    STAT_POP_EMPTY = 2'd1,
    STAT_PUSH_FULL = 2'd2
  } status_t;

  // sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_CAP
  } state_t;

  // result summary from control to the output stage
  typedef struct packed {
    logic       valid;
    status_t    status;
    logic [4:0] occupancy;
    logic       is_empty;
  } rsp_info_t;

endpackage

// ===== design/dq_ring_mem.sv =====
module dq_ring_mem import dq_pkg::*; #(
  parameter int DEPTH     = DEPTH_DEF,
  parameter int WORD_BITS = WORD_BITS_DEF,
  localparam int IDX_W    = $clog2(DEPTH)
) (
  input  logic                 clk,
  input  logic                 wr_en,
  input  logic [IDX_W-1:0]     wr_addr,
  input  logic [WORD_BITS-1:0] wr_data,
  input  logic [IDX_W-1:0]     rd_front_addr,
  input  logic [IDX_W-1:0]     rd_back_addr,
  output logic [WORD_BITS-1:0] rd_front_data,
  output logic [WORD_BITS-1:0] rd_back_data
);

  logic [WORD_BITS-1:0] mem [DEPTH];
  logic [WORD_BITS-1:0] rd_front_data_r;
  logic [WORD_BITS-1:0] rd_back_data_r;

  // single write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // two registered read ports
  always_ff @(posedge clk) begin
    rd_front_data_r <= mem[rd_front_addr];
    rd_back_data_r  <= mem[rd_back_addr];
  end

  assign rd_front_data = rd_front_data_r;
  assign rd_back_data  = rd_back_data_r;

endmodule

// ===== design/dq_ctrl.sv =====
module dq_ctrl import dq_pkg::*; #(
  parameter int DEPTH     = DEPTH_DEF,
  parameter int WORD_BITS = WORD_BITS_DEF,
  localparam int IDX_W    = $clog2(DEPTH),
  localparam int CNT_W    = $clog2(DEPTH + 1)
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [2:0]           in_req_type,
  input  logic [31:0]          in_item_word,
  input  logic                 out_free,
  output logic                 wr_en,
  output logic [IDX_W-1:0]     wr_addr,
  output logic [WORD_BITS-1:0] wr_data,
  output logic [IDX_W-1:0]     rd_front_addr,
  output logic [IDX_W-1:0]     rd_back_addr,
  output rsp_info_t            rsp
);

  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  state_t           state_r, state_nxt;
  logic [IDX_W-1:0] front_r, front_nxt;
  logic [IDX_W-1:0] back_r, back_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  status_t          status_r, status_nxt;
  logic             acc;
  logic [IDX_W-1:0] front_prev, back_next, front_next, back_prev;

  assign acc      = (state_r == ST_IDLE) && in_valid;
  assign in_stall = (state_r != ST_IDLE);

  // ring neighbors
  assign front_prev = (front_r == '0) ? IDX_LAST : front_r - IDX_W'(1);
  assign front_next = (front_r == IDX_LAST) ? '0 : front_r + IDX_W'(1);
  assign back_prev  = (back_r == '0) ? IDX_LAST : back_r - IDX_W'(1);
  assign back_next  = (back_r == IDX_LAST) ? '0 : back_r + IDX_W'(1);

  // request decode and index update
  always_comb begin
    front_nxt  = front_r;
    back_nxt   = back_r;
    count_nxt  = count_r;
    status_nxt = status_r;
    wr_en      = 1'b0;
    wr_addr    = front_r;
    wr_data    = WORD_BITS'(in_item_word);
    if (acc) begin
      status_nxt = STAT_OK;
      unique case (in_req_type) inside
        REQ_PUSH_FRONT, REQ_PUSH_BACK: begin
          if (count_r == CNT_FULL) begin
            status_nxt = STAT_PUSH_FULL;
          end else if (count_r == '0) begin
            wr_en     = 1'b1;
            wr_addr   = front_r;
            back_nxt  = front_r;
            count_nxt = CNT_W'(1);
          end else if (in_req_type == REQ_PUSH_FRONT) begin
            wr_en     = 1'b1;
            wr_addr   = front_prev;
            front_nxt = front_prev;
            count_nxt = count_r + CNT_W'(1);
          end else begin
            wr_en     = 1'b1;
            wr_addr   = back_next;
            back_nxt  = back_next;
            count_nxt = count_r + CNT_W'(1);
          end
        end
        REQ_POP_FRONT, REQ_POP_BACK: begin
          if (count_r == '0) begin
            status_nxt = STAT_POP_EMPTY;
          end else begin
            if (count_r > CNT_W'(1)) begin
              if (in_req_type == REQ_POP_FRONT) begin
                front_nxt = front_next;
              end else begin
                back_nxt = back_prev;
              end
            end
            count_nxt = count_r - CNT_W'(1);
          end
        end
        default: begin
          // query and unused codes leave indices and count unchanged
        end
      endcase
    end
  end

  // sequencer: update, read back, capture
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (in_valid) state_nxt = ST_READ;
      ST_READ: state_nxt = ST_CAP;
      ST_CAP:  if (out_free) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      front_r  <= '0;
      back_r   <= '0;
      count_r  <= '0;
      status_r <= STAT_OK;
    end else begin
      state_r  <= state_nxt;
      front_r  <= front_nxt;
      back_r   <= back_nxt;
      count_r  <= count_nxt;
      status_r <= status_nxt;
    end
  end

  // memory reads follow the live indices
  assign rd_front_addr = front_r;
  assign rd_back_addr  = back_r;

  // summary for the output stage
  assign rsp.valid     = (state_r == ST_CAP);
  assign rsp.status    = status_r;
  assign rsp.occupancy = 5'(count_r);
  assign rsp.is_empty  = (count_r == '0);

  // checks
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_FULL)
    else $error("item count beyond depth");

  a_write_on_accept: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en |-> acc)
    else $error("memory write outside an accepted transaction");

  a_accept_reads: assert property (@(posedge clk) disable iff (!rst_n)
    acc |=> (state_r == ST_READ))
    else $error("accepted transaction did not start a read");

  a_full_push_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (acc && count_r == CNT_FULL &&
     (in_req_type == REQ_PUSH_FRONT || in_req_type == REQ_PUSH_BACK))
    |=> ($stable(count_r) && $stable(front_r) && $stable(back_r)))
    else $error("push into full queue changed state");

endmodule

// ===== design/double_ended_queue_top.sv =====
// flow: an accepted request updates the indices and writes the memory,
//   then the ring memory is read back and the result is captured into the
//   output register once it is free; only then is a new request taken
// reset: synchronous active-low reset clears indices, count and sequencer;
//   ring memory contents are not cleared; output words read as zero while empty
module double_ended_queue_top import dq_pkg::*; #(
  parameter int DEPTH     = DEPTH_DEF,
  parameter int WORD_BITS = WORD_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  in_req_type,
  input  logic [31:0] in_item_word,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_status,
  output logic [31:0] out_front_word,
  output logic [31:0] out_back_word,
  output logic [4:0]  out_occupancy,
  output logic        out_is_empty
);

  localparam int IDX_W = $clog2(DEPTH);

  logic                 wr_en;
  logic [IDX_W-1:0]     wr_addr;
  logic [WORD_BITS-1:0] wr_data;
  logic [IDX_W-1:0]     rd_front_addr, rd_back_addr;
  logic [WORD_BITS-1:0] rd_front_data, rd_back_data;
  rsp_info_t            rsp;
  logic                 out_free;
  logic [63:0]          front_ext, back_ext;

  logic        out_valid_r;
  logic [1:0]  status_r;
  logic [31:0] front_r, back_r;
  logic [4:0]  occ_r;
  logic        empty_r;

  dq_ctrl #(
    .DEPTH     (DEPTH),
    .WORD_BITS (WORD_BITS)
  ) u_ctrl (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_req_type   (in_req_type),
    .in_item_word  (in_item_word),
    .out_free      (out_free),
    .wr_en         (wr_en),
    .wr_addr       (wr_addr),
    .wr_data       (wr_data),
    .rd_front_addr (rd_front_addr),
    .rd_back_addr  (rd_back_addr),
    .rsp           (rsp)
  );

  dq_ring_mem #(
    .DEPTH     (DEPTH),
    .WORD_BITS (WORD_BITS)
  ) u_mem (
    .clk           (clk),
    .wr_en         (wr_en),
    .wr_addr       (wr_addr),
    .wr_data       (wr_data),
    .rd_front_addr (rd_front_addr),
    .rd_back_addr  (rd_back_addr),
    .rd_front_data (rd_front_data),
    .rd_back_data  (rd_back_data)
  );

  // output register is free when empty or being taken
  assign out_free = !out_valid_r || !out_stall;

  assign front_ext = 64'(rd_front_data);
  assign back_ext  = 64'(rd_back_data);

  // output valid flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= rsp.valid;
    end
  end

  // output payload
  always_ff @(posedge clk) begin
    if (out_free && rsp.valid) begin
      status_r <= rsp.status;
      occ_r    <= rsp.occupancy;
      empty_r  <= rsp.is_empty;
      front_r  <= rsp.is_empty ? 32'd0 : front_ext[31:0];
      back_r   <= rsp.is_empty ? 32'd0 : back_ext[31:0];
    end
  end

  assign out_valid      = out_valid_r;
  assign out_status     = status_r;
  assign out_front_word = front_r;
  assign out_back_word  = back_r;
  assign out_occupancy  = occ_r;
  assign out_is_empty   = empty_r;

endmodule
